// ===== design/sdo_pkg.sv =====
// ----------------------------------------------------------------------------
// sdo_pkg
// Shared types, command codes and error codes of the expedited SDO server.
// ----------------------------------------------------------------------------
package sdo_pkg;

   localparam int DictEntriesDefault = 16;

   localparam logic       OpRequest = 1'b0;
   localparam logic       OpDefine  = 1'b1;

   localparam logic       KindResponse  = 1'b0;
   localparam logic       KindEmergency = 1'b1;

   localparam logic [10:0] SdoTxIdBase = 11'h580;

   localparam logic [7:0] CmdRead       = 8'h40;
   localparam logic [7:0] CmdWrite1     = 8'h2F;
   localparam logic [7:0] CmdWrite2     = 8'h2B;
   localparam logic [7:0] CmdWrite4     = 8'h23;
   localparam logic [7:0] CmdReadResp1  = 8'h4F;
   localparam logic [7:0] CmdReadResp2  = 8'h4B;
   localparam logic [7:0] CmdReadResp4  = 8'h43;
   localparam logic [7:0] CmdWriteResp  = 8'h60;
   localparam logic [7:0] CmdNone       = 8'h00;

   localparam logic [3:0] Size0 = 4'd0;
   localparam logic [3:0] Size1 = 4'd1;
   localparam logic [3:0] Size2 = 4'd2;
   localparam logic [3:0] Size4 = 4'd4;

   localparam logic [2:0] ErrNone     = 3'd0;
   localparam logic [2:0] ErrNotFound = 3'd1;
   localparam logic [2:0] ErrBadSize  = 3'd2;
   localparam logic [2:0] ErrBadCmd   = 3'd3;
   localparam logic [2:0] ErrMismatch = 3'd4;

   localparam logic [6:0] NodeIdReset = 7'd1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  request_cmd;
      logic [15:0] object_index;
      logic [7:0]  object_subindex;
      logic [31:0] payload_in;
      logic [3:0]  slot;
      logic [3:0]  entry_size;
   } req_item_type;

   typedef struct packed {
      logic        kind;
      logic [10:0] can_id;
      logic [7:0]  response_cmd;
      logic [15:0] echo_index;
      logic [7:0]  echo_subindex;
      logic [31:0] payload_out;
      logic [2:0]  error_code;
   } rsp_item_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  bytes;
      logic [31:0] value;
   } lookup_type;

   typedef struct packed {
      logic        define_we;
      logic        store_we;
      logic [3:0]  slot;
      logic [3:0]  bytes;
      logic [31:0] value;
   } update_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  response_cmd;
      logic [31:0] payload_out;
      logic [2:0]  error_code;
      logic        store;
      logic [31:0] store_value;
   } verdict_type;

endpackage

// ===== design/sdo_req_if.sv =====
// ----------------------------------------------------------------------------
// sdo_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
interface sdo_req_if import sdo_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== design/sdo_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sdo_rsp_if
// Result channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface sdo_rsp_if import sdo_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== design/sdo_dict.sv =====
// ----------------------------------------------------------------------------
// sdo_dict
// Object dictionary slots with associative lookup; lowest matching slot wins.
// ----------------------------------------------------------------------------
module sdo_dict import sdo_pkg::*; #(
   parameter int DICT_ENTRIES = DictEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [23:0] key,
   input  update_type  update,
   output lookup_type  lookup
);

   localparam int IdxW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;

   logic [DICT_ENTRIES-1:0] valid_ff;
   logic [DICT_ENTRIES-1:0] valid_in;
   logic [23:0]             key_ff   [DICT_ENTRIES];
   logic [3:0]              bytes_ff [DICT_ENTRIES];
   logic [31:0]             value_ff [DICT_ENTRIES];

   logic [IdxW-1:0] hit;
   logic            found;
   logic [31:0]     slot_wide;
   logic [IdxW-1:0] slot_idx;
   logic            slot_ok;

   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int i = DICT_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == key)) begin
            found = 1'b1;
            hit   = IdxW'(i);
         end
      end
   end

   assign lookup.found = found;
   assign lookup.bytes = bytes_ff[hit];
   assign lookup.value = value_ff[hit];

   assign slot_wide = {28'd0, update.slot};
   assign slot_idx  = slot_wide[IdxW-1:0];
   assign slot_ok   = (slot_wide < 32'(DICT_ENTRIES));

   always_comb begin
      valid_in = valid_ff;
      if (update.define_we && slot_ok) begin
         valid_in[slot_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update.define_we && slot_ok) begin
         key_ff[slot_idx]   <= key;
         bytes_ff[slot_idx] <= update.bytes;
         value_ff[slot_idx] <= update.value;
      end else if (update.store_we) begin
         value_ff[hit] <= update.value;
      end
   end

endmodule

// ===== design/sdo_eval.sv =====
// ----------------------------------------------------------------------------
// sdo_eval
// Command decode and size checks; builds the response or emergency verdict.
// ----------------------------------------------------------------------------
module sdo_eval import sdo_pkg::*; (
   input  logic [7:0]  request_cmd,
   input  logic [31:0] payload_in,
   input  lookup_type  lookup,
   output verdict_type verdict
);

   logic [2:0]  err;
   logic [7:0]  rcmd;
   logic [31:0] mask;
   logic [31:0] data;
   logic [3:0]  want;
   logic        store;

   always_comb begin
      err   = ErrNone;
      rcmd  = CmdNone;
      mask  = 32'hFFFF_FFFF;
      data  = '0;
      want  = Size0;
      store = 1'b0;
      if (!lookup.found) begin
         err = ErrNotFound;
      end else if (request_cmd == CmdRead) begin
         case (lookup.bytes)
            Size1: begin
               rcmd = CmdReadResp1;
               mask = 32'h0000_00FF;
            end
            Size2: begin
               rcmd = CmdReadResp2;
               mask = 32'h0000_FFFF;
            end
            Size4: begin
               rcmd = CmdReadResp4;
            end
            default: begin
               err = ErrBadSize;
            end
         endcase
         data = lookup.value & mask;
      end else begin
         case (request_cmd)
            CmdWrite1: begin
               want = Size1;
               mask = 32'h0000_00FF;
            end
            CmdWrite2: begin
               want = Size2;
               mask = 32'h0000_FFFF;
            end
            CmdWrite4: want = Size4;
            default:   want = Size0;
         endcase
         if (want == Size0) begin
            err = ErrBadCmd;
         end else if (want != lookup.bytes) begin
            err = ErrMismatch;
         end else begin
            store = 1'b1;
            rcmd  = CmdWriteResp;
         end
      end

      verdict.store       = store;
      verdict.store_value = payload_in & mask;
      verdict.error_code  = err;
      if (err != ErrNone) begin
         verdict.kind         = KindEmergency;
         verdict.response_cmd = CmdNone;
         verdict.payload_out  = '0;
      end else begin
         verdict.kind         = KindResponse;
         verdict.response_cmd = rcmd;
         verdict.payload_out  = data;
      end
   end

endmodule

// ===== design/sdo_expedited_server.sv =====
// ----------------------------------------------------------------------------
// sdo_expedited_server
// Expedited SDO server over an internal object dictionary.
// ----------------------------------------------------------------------------
//   channel    direction  handshake      transaction
//   req_chan   in         valid/ready    request or dictionary define
//   rsp_chan   out        valid/ready    SDO response or emergency report
//   csr_*      in         write enable   node id
//
// One transaction per cycle unless a full result register stalls: a request
// is registered, looked up and decided from that register, and lands in the
// result register; dictionary match and update sit between the two registers.
// Defines produce no result and never wait on the result side.
// Reset clears all slot valid bits and sets the node id to 1.
// ----------------------------------------------------------------------------
module sdo_expedited_server import sdo_pkg::*; #(
   parameter int DICT_ENTRIES = DictEntriesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   sdo_req_if.sink    req_chan,
   sdo_rsp_if.source  rsp_chan
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         s1_advance;
   logic         s1_is_req;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   logic [6:0]   node_id_ff;
   logic [6:0]   node_id_in;

   lookup_type   lookup;
   update_type   update;
   verdict_type  verdict;

   assign s1_is_req  = (s1_item_ff.operation == OpRequest);
   assign s1_advance = s1_valid_ff && (!s1_is_req || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   assign s1_valid_in = (req_chan.valid && req_chan.ready) ? 1'b1 :
                        (s1_advance ? 1'b0 : s1_valid_ff);

   assign update.define_we = s1_advance && !s1_is_req;
   assign update.store_we  = s1_advance && s1_is_req && verdict.store;
   assign update.slot      = s1_item_ff.slot;
   assign update.bytes     = s1_item_ff.entry_size;
   assign update.value     = s1_is_req ? verdict.store_value : s1_item_ff.payload_in;

   sdo_dict #(
      .DICT_ENTRIES (DICT_ENTRIES)
   ) u_dict (
      .clock  (clock),
      .reset  (reset),
      .key    ({s1_item_ff.object_index, s1_item_ff.object_subindex}),
      .update (update),
      .lookup (lookup)
   );

   sdo_eval u_eval (
      .request_cmd (s1_item_ff.request_cmd),
      .payload_in  (s1_item_ff.payload_in),
      .lookup      (lookup),
      .verdict     (verdict)
   );

   always_comb begin
      rsp_item_in.kind          = verdict.kind;
      rsp_item_in.can_id        = SdoTxIdBase + {4'd0, node_id_ff};
      rsp_item_in.response_cmd  = verdict.response_cmd;
      rsp_item_in.echo_index    = s1_item_ff.object_index;
      rsp_item_in.echo_subindex = s1_item_ff.object_subindex;
      rsp_item_in.payload_out   = verdict.payload_out;
      rsp_item_in.error_code    = verdict.error_code;
   end

   assign rsp_valid_in = (s1_advance && s1_is_req) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   assign node_id_in = csr_write_enable ? csr_write_data : node_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         node_id_ff   <= NodeIdReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         node_id_ff   <= node_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_item_ff <= req_chan.item;
      end
      if (s1_advance && s1_is_req) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item  = rsp_item_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the expedited SDO server. A driver and a monitor run
// as clocked processes; a predictor keeps its own copy of the object dictionary
// and node id, works out the answer to each accepted request and checks every
// response transaction in order. Directed cases come first, then three random
// phases with different back-pressure and node ids.
// ----------------------------------------------------------------------------
module testbench;
   import sdo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int PoolKeys   = 6;
   localparam int PhaseItems = 500;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   sdo_req_if req_if ();
   sdo_rsp_if rsp_if ();

   sdo_expedited_server uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   logic        dict_live  [DictEntriesDefault];
   logic [23:0] dict_key   [DictEntriesDefault];
   logic [3:0]  dict_size  [DictEntriesDefault];
   logic [31:0] dict_value [DictEntriesDefault];
   logic [6:0]  node_id_model;

   logic [23:0] key_pool [PoolKeys];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cycle_count;
   int unsigned mismatches;
   bit          req_fire;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit predict_response(input req_item_type r, output rsp_item_type rsp);
      logic [23:0] key;
      logic [3:0]  want;
      int          hit;
      key = {r.object_index, r.object_subindex};
      rsp = '0;
      rsp.kind = KindResponse;
      rsp.can_id = SdoTxIdBase + 11'(node_id_model);
      rsp.echo_index = r.object_index;
      rsp.echo_subindex = r.object_subindex;
      rsp.error_code = ErrNone;
      if (r.operation == OpDefine) begin
         if (r.slot < DictEntriesDefault) begin
            dict_live[r.slot] = 1'b1;
            dict_key[r.slot] = key;
            dict_size[r.slot] = r.entry_size;
            dict_value[r.slot] = r.payload_in;
         end
         return 1'b0;
      end
      hit = -1;
      for (int i = DictEntriesDefault - 1; i >= 0; i--)
         if (dict_live[i] && dict_key[i] == key)
            hit = i;
      if (hit < 0) begin
         rsp.error_code = ErrNotFound;
      end else if (r.request_cmd == CmdRead) begin
         case (dict_size[hit])
            Size1: begin
               rsp.response_cmd = CmdReadResp1;
               rsp.payload_out = dict_value[hit] & 32'h0000_00FF;
            end
            Size2: begin
               rsp.response_cmd = CmdReadResp2;
               rsp.payload_out = dict_value[hit] & 32'h0000_FFFF;
            end
            Size4: begin
               rsp.response_cmd = CmdReadResp4;
               rsp.payload_out = dict_value[hit];
            end
            default: rsp.error_code = ErrBadSize;
         endcase
      end else begin
         case (r.request_cmd)
            CmdWrite1: want = Size1;
            CmdWrite2: want = Size2;
            CmdWrite4: want = Size4;
            default:   want = Size0;
         endcase
         if (want == Size0) begin
            rsp.error_code = ErrBadCmd;
         end else if (want != dict_size[hit]) begin
            rsp.error_code = ErrMismatch;
         end else begin
            dict_value[hit] = r.payload_in & ((want == Size1) ? 32'h0000_00FF :
                                              (want == Size2) ? 32'h0000_FFFF : 32'hFFFF_FFFF);
            rsp.response_cmd = CmdWriteResp;
         end
      end
      if (rsp.error_code != ErrNone) begin
         rsp.kind = KindEmergency;
         rsp.response_cmd = CmdNone;
         rsp.payload_out = '0;
      end
      return 1'b1;
   endfunction

   function automatic void queue_request(logic [7:0] cmd, logic [15:0] idx, logic [7:0] sub,
                                         logic [31:0] value);
      req_item_type r;
      r.operation = OpRequest;
      r.request_cmd = cmd;
      r.object_index = idx;
      r.object_subindex = sub;
      r.payload_in = value;
      r.slot = 4'($urandom);
      r.entry_size = 4'($urandom_range(8));
      pending_reqs.push_back(r);
   endfunction

   function automatic void queue_define(logic [3:0] slot_no, logic [15:0] idx, logic [7:0] sub,
                                        logic [3:0] size, logic [31:0] value);
      req_item_type r;
      r.operation = OpDefine;
      r.request_cmd = 8'($urandom);
      r.object_index = idx;
      r.object_subindex = sub;
      r.payload_in = value;
      r.slot = slot_no;
      r.entry_size = size;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [3:0] pick_size();
      if ($urandom_range(99) >= 75)
         return 4'($urandom_range(8));
      case ($urandom_range(2))
         0:       return Size1;
         1:       return Size2;
         default: return Size4;
      endcase
   endfunction

   task automatic show_response(string label, rsp_item_type r);
      $display("%s kind %0d id %h cmd %h index %h sub %h data %h err %0d", label, r.kind,
               r.can_id, r.response_cmd, r.echo_index, r.echo_subindex, r.payload_out,
               r.error_code);
   endtask

   task automatic queue_directed();
      @(posedge clock);
      queue_request(CmdRead, 16'h1000, 8'h00, 32'h0);
      queue_define(4'd0, 16'h2000, 8'h01, Size1, 32'hA5A5_A5A5);
      queue_define(4'd1, 16'h2000, 8'h02, Size2, 32'hDEAD_BEEF);
      queue_define(4'd2, 16'h2000, 8'h03, Size4, 32'hFFFF_FFFF);
      queue_define(4'd3, 16'hFFFF, 8'hFF, Size0, 32'h0);
      queue_define(4'd15, 16'h0000, 8'h00, 4'd8, 32'h1234_5678);
      queue_define(4'd5, 16'h2000, 8'h01, Size4, 32'h1111_1111);
      queue_request(CmdRead, 16'h2000, 8'h01, 32'h0);
      queue_request(CmdRead, 16'h2000, 8'h02, 32'hFFFF_FFFF);
      queue_request(CmdRead, 16'h2000, 8'h03, 32'h0);
      queue_request(CmdRead, 16'hFFFF, 8'hFF, 32'h0);
      queue_request(CmdRead, 16'h0000, 8'h00, 32'h0);
      queue_request(CmdWrite1, 16'h2000, 8'h01, 32'hFFFF_FF5A);
      queue_request(CmdRead, 16'h2000, 8'h01, 32'h0);
      queue_request(CmdWrite4, 16'h2000, 8'h01, 32'hFFFF_FFFF);
      queue_request(CmdWrite2, 16'h2000, 8'h02, 32'h0000_FFFF);
      queue_request(CmdWrite4, 16'h2000, 8'h03, 32'h0);
      queue_request(CmdRead, 16'h2000, 8'h03, 32'h0);
      queue_request(8'hFF, 16'h2000, 8'h02, 32'h0);
      queue_request(8'h00, 16'hFFFF, 8'hFF, 32'h0);
      queue_request(8'hFF, 16'h1234, 8'h56, 32'h0);
      queue_request(CmdWrite1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_request(CmdRead, 16'h2000, 8'h02, 32'h0);
   endtask

   task automatic queue_random(int count);
      logic [23:0] key;
      logic [7:0]  cmd;
      int unsigned roll;
      @(posedge clock);
      foreach (key_pool[k])
         key_pool[k] = 24'($urandom);
      foreach (key_pool[k])
         queue_define(4'($urandom_range(15)), key_pool[k][23:8], key_pool[k][7:0], pick_size(),
                      $urandom);
      repeat (count) begin
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(PoolKeys - 1)]
                                         : 24'($urandom);
         if ($urandom_range(99) < 10) begin
            queue_define(4'($urandom_range(15)), key[23:8], key[7:0], pick_size(), $urandom);
         end else begin
            roll = $urandom_range(99);
            if (roll < 35)
               cmd = CmdRead;
            else if (roll < 50)
               cmd = CmdWrite1;
            else if (roll < 65)
               cmd = CmdWrite2;
            else if (roll < 80)
               cmd = CmdWrite4;
            else
               cmd = 8'($urandom);
            queue_request(cmd, key[23:8], key[7:0], $urandom);
         end
      end
   endtask

   task automatic settle(int hold);
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (hold) @(negedge clock);
   endtask

   task automatic write_node_id(logic [6:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // driver: hold the transaction until taken, then advance
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.item <= pending_reqs.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: predict on request, compare on response
   always @(posedge clock) begin
      rsp_item_type predicted;
      rsp_item_type oldest;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         req_fire = !reset && req_if.valid && req_if.ready;
         if (reset) begin
            node_id_model = NodeIdReset;
            foreach (dict_live[i])
               dict_live[i] = 1'b0;
         end else begin
            if (csr_write_enable)
               node_id_model = csr_write_data;
            if (req_fire) begin
               if (predict_response(req_if.item, predicted))
                  expected_rsps.push_back(predicted);
            end
            if (rsp_if.valid && rsp_if.ready) begin
               if (expected_rsps.size() == 0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     show_response("unexpected response:", rsp_if.item);
               end else begin
                  oldest = expected_rsps.pop_front();
                  if (rsp_if.item !== oldest) begin
                     mismatches++;
                     if (mismatches <= 10) begin
                        show_response("mismatch, expected:", oldest);
                        show_response("          actual:  ", rsp_if.item);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.item = '0;
      rsp_if.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      send_idle_pct = 9;
      recv_idle_pct = 48;
      cycle_count = 0;
      mismatches = 0;
      req_fire = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_directed();
      settle(4);
      write_node_id(7'd127);
      queue_random(PhaseItems);
      settle(4);

      send_idle_pct = 48;
      recv_idle_pct = 9;
      write_node_id(7'($urandom_range(126, 2)));
      queue_random(PhaseItems);
      settle(4);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_node_id(NodeIdReset);
      queue_random(PhaseItems);
      settle(8);

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
